// ===== rtl/bfi_pkg.sv =====
// package for the tape-language interpreter core
// constants, command and status codes, controller/datapath structs; no dependencies
`default_nettype none
package bfi_pkg;
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 4096;
    localparam int LOOP_DEPTH = 64;
    localparam int PA_W = $clog2(PROG_DEPTH);
    localparam int PL_W = PA_W + 1;
    localparam int TA_W = $clog2(TAPE_DEPTH);
    localparam int LA_W = $clog2(LOOP_DEPTH);
    localparam int LD_W = LA_W + 1;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STEP    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [2:0] OP_INC   = 3'd0;
    localparam logic [2:0] OP_DEC   = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_LEFT  = 3'd3;
    localparam logic [2:0] OP_OPEN  = 3'd4;
    localparam logic [2:0] OP_CLOSE = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;
    localparam logic [2:0] OP_WRITE = 3'd7;

    localparam logic [2:0] ST_READY    = 3'd0;
    localparam logic [2:0] ST_RUN      = 3'd1;
    localparam logic [2:0] ST_WAIT     = 3'd2;
    localparam logic [2:0] ST_HALT     = 3'd3;
    localparam logic [2:0] ST_TAPE_ERR = 3'd4;
    localparam logic [2:0] ST_LOOP_ERR = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // datapath commands
    localparam logic [3:0] DC_NONE     = 4'd0;
    localparam logic [3:0] DC_LOAD     = 4'd1;
    localparam logic [3:0] DC_FETCH    = 4'd2; // read program[pc] and tape[cp]
    localparam logic [3:0] DC_EXEC     = 4'd3; // execute fetched op
    localparam logic [3:0] DC_SKIP_RD  = 4'd4; // read program[scan]
    localparam logic [3:0] DC_SKIP_EV  = 4'd5; // evaluate scanned op
    localparam logic [3:0] DC_CLEAR    = 4'd6; // clear one tape cell
    localparam logic [3:0] DC_RESTART  = 4'd7; // clear registers, start sweep

    typedef struct packed {
        logic [3:0]  cmd;
        logic [2:0]  instr_code;
        logic [7:0]  in_byte;
        logic        in_valid;
        logic        in_eof;
    } t_dp_cmd;

    typedef struct packed {
        logic        result;      // item finished this cycle
        logic        skip_more;   // scan continues
        logic        clear_done;  // tape sweep finished
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_byte;
    } t_dp_stat;
endpackage
`default_nettype wire

// ===== rtl/bfi_datapath.sv =====
// datapath: program store, tape, loop stack and run registers
// uses bfi_pkg
`default_nettype none
module bfi_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bfi_pkg::t_dp_cmd  i_cmd,
    output bfi_pkg::t_dp_stat      o_stat,
    output logic [2:0]             o_run
);
    import bfi_pkg::*;

    logic [2:0]      r_prog [PROG_DEPTH];
    logic [7:0]      r_tape [TAPE_DEPTH];
    logic [PA_W-1:0] r_lstk [LOOP_DEPTH];

    logic [PL_W-1:0] r_plen, r_pc, r_scan;
    logic [TA_W-1:0] r_cp, r_clr;
    logic [LD_W-1:0] r_ldepth;
    logic [PL_W-1:0] r_nest;
    logic [2:0]      r_run, r_op, r_sop;
    logic [7:0]      r_cell;
    logic [PA_W-1:0] r_top;
    logic            r_fetch_ok;

    logic            prog_full, pc_ok, scan_ok;
    assign prog_full = (r_plen == PL_W'(PROG_DEPTH));
    assign pc_ok     = (r_pc < r_plen);
    assign scan_ok   = (r_scan < r_plen);

    // memories: program store
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmd == DC_LOAD && !prog_full)
            r_prog[r_plen[PA_W-1:0]] <= i_cmd.instr_code;
        if (i_cmd.cmd == DC_FETCH)
            r_op <= r_prog[r_pc[PA_W-1:0]];
        if (i_cmd.cmd == DC_SKIP_RD)
            r_sop <= r_prog[r_scan[PA_W-1:0]];
    end

    logic            tape_we;
    logic [TA_W-1:0] tape_wa;
    logic [7:0]      tape_wd;
    always_comb begin
        tape_we = 1'b0;
        tape_wa = r_cp;
        tape_wd = r_cell;
        if (i_cmd.cmd == DC_CLEAR) begin
            tape_we = 1'b1;
            tape_wa = r_clr;
            tape_wd = 8'd0;
        end else if (i_cmd.cmd == DC_EXEC && r_fetch_ok) begin
            unique case (r_op)
                OP_INC:  begin tape_we = 1'b1; tape_wd = r_cell + 8'd1; end
                OP_DEC:  begin tape_we = 1'b1; tape_wd = r_cell - 8'd1; end
                OP_READ: begin tape_we = i_cmd.in_valid; tape_wd = i_cmd.in_byte; end
                default: tape_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tape_we)
            r_tape[tape_wa] <= tape_wd;
        if (i_cmd.cmd == DC_FETCH)
            r_cell <= r_tape[r_cp];
    end

    // loop stack
    logic stk_push;
    assign stk_push = i_cmd.cmd == DC_EXEC && r_fetch_ok && r_op == OP_OPEN &&
                      r_cell != 8'd0 && r_ldepth < LD_W'(LOOP_DEPTH);
    always_ff @(posedge i_clk) begin
        if (stk_push)
            r_lstk[r_ldepth[LA_W-1:0]] <= r_pc[PA_W-1:0];
        if (i_cmd.cmd == DC_FETCH)
            r_top <= r_lstk[r_ldepth[LA_W-1:0] - LA_W'(1)];
    end

    t_dp_stat st;
    logic [PL_W-1:0] n_pc, n_plen, n_scan, n_nest;
    logic [TA_W-1:0] n_cp, n_clr;
    logic [LD_W-1:0] n_ldepth;
    logic [2:0]      n_run;
    logic            n_fetch_ok;

    always_comb begin
        n_pc = r_pc; n_plen = r_plen; n_scan = r_scan; n_nest = r_nest;
        n_cp = r_cp; n_clr = r_clr; n_ldepth = r_ldepth; n_run = r_run;
        n_fetch_ok = r_fetch_ok;
        st = '0;
        st.status = r_run;
        unique case (i_cmd.cmd)
            DC_LOAD: begin
                st.result = 1'b1;
                if (prog_full) st.status = ST_FULL;
                else n_plen = r_plen + PL_W'(1);
            end
            DC_FETCH: begin
                n_fetch_ok = pc_ok;
            end
            DC_EXEC: begin
                st.result = 1'b1;
                if (!r_fetch_ok) begin
                    n_run = ST_HALT;
                end else begin
                    n_run = ST_RUN;
                    unique case (r_op)
                        OP_INC, OP_DEC: n_pc = r_pc + PL_W'(1);
                        OP_RIGHT: begin
                            if (r_cp == TA_W'(TAPE_DEPTH - 1)) n_run = ST_TAPE_ERR;
                            else begin n_cp = r_cp + TA_W'(1); n_pc = r_pc + PL_W'(1); end
                        end
                        OP_LEFT: begin
                            if (r_cp == '0) n_run = ST_TAPE_ERR;
                            else begin n_cp = r_cp - TA_W'(1); n_pc = r_pc + PL_W'(1); end
                        end
                        OP_OPEN: begin
                            if (r_cell != 8'd0) begin
                                if (r_ldepth >= LD_W'(LOOP_DEPTH)) n_run = ST_LOOP_ERR;
                                else begin
                                    n_ldepth = r_ldepth + LD_W'(1);
                                    n_pc = r_pc + PL_W'(1);
                                end
                            end else begin
                                // zero cell: scan forward for the matching close
                                st.result = 1'b0;
                                st.skip_more = 1'b1;
                                n_scan = r_pc + PL_W'(1);
                                n_nest = '0;
                            end
                        end
                        OP_CLOSE: begin
                            if (r_ldepth == '0) n_run = ST_HALT;
                            else begin
                                n_ldepth = r_ldepth - LD_W'(1);
                                n_pc = {1'b0, r_top};
                            end
                        end
                        OP_READ: begin
                            if (i_cmd.in_valid) n_pc = r_pc + PL_W'(1);
                            else if (i_cmd.in_eof) n_run = ST_HALT;
                            else n_run = ST_WAIT;
                        end
                        default: begin
                            st.out_valid = 1'b1;
                            st.out_byte = r_cell;
                            n_pc = r_pc + PL_W'(1);
                        end
                    endcase
                end
                st.status = n_run;
            end
            DC_SKIP_RD: begin
                if (!scan_ok) begin
                    st.result = 1'b1;
                    n_pc = r_plen;
                    n_run = ST_HALT;
                    st.status = ST_HALT;
                end else begin
                    st.skip_more = 1'b1;
                end
            end
            DC_SKIP_EV: begin
                st.skip_more = 1'b1;
                n_scan = r_scan + PL_W'(1);
                if (r_sop == OP_OPEN) n_nest = r_nest + PL_W'(1);
                else if (r_sop == OP_CLOSE) begin
                    if (r_nest == '0) begin
                        st.skip_more = 1'b0;
                        st.result = 1'b1;
                        n_pc = r_scan + PL_W'(1);
                        if (n_pc >= r_plen) n_run = ST_HALT;
                        st.status = n_run;
                    end else n_nest = r_nest - PL_W'(1);
                end
            end
            DC_CLEAR: begin
                n_clr = r_clr + TA_W'(1);
                st.clear_done = (r_clr == TA_W'(TAPE_DEPTH - 1));
                st.result = st.clear_done;
                st.status = ST_READY;
            end
            DC_RESTART: begin
                n_pc = '0; n_cp = '0; n_ldepth = '0; n_run = ST_READY; n_clr = '0;
            end
            default: ;
        endcase
    end
    assign o_stat = st;
    assign o_run  = r_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= '0; r_pc <= '0; r_cp <= '0; r_ldepth <= '0;
            r_run <= ST_READY; r_clr <= '0; r_fetch_ok <= 1'b0;
            r_scan <= '0; r_nest <= '0;
        end else begin
            r_plen <= n_plen; r_pc <= n_pc; r_cp <= n_cp; r_ldepth <= n_ldepth;
            r_run <= n_run; r_clr <= n_clr; r_fetch_ok <= n_fetch_ok;
            r_scan <= n_scan; r_nest <= n_nest;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/bfi_control.sv =====
// controller: sequences fetch/execute, bracket scan and the tape clearing sweep
// uses bfi_pkg
`default_nettype none
module bfi_control (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [2:0]        i_instr_code,
    input  wire logic [7:0]        i_in_byte,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_eof,
    input  wire logic [2:0]        i_run_status,
    output bfi_pkg::t_dp_cmd       o_cmd,
    input  wire bfi_pkg::t_dp_stat i_stat,
    output logic                   o_done,
    input  wire logic              i_out_free
);
    import bfi_pkg::*;

    localparam logic [2:0] S_CLR   = 3'd0; // sweep after reset or restart
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SRD   = 3'd3;
    localparam logic [2:0] S_SEV   = 3'd4;
    localparam logic [2:0] S_RST   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_restart, n_restart; // sweep owes a result
    logic [2:0] r_icode, n_icode;
    logic [7:0] r_ibyte, n_ibyte;
    logic       r_iv, n_iv, r_ie, n_ie;

    logic take, live;
    assign live = (i_run_status == ST_READY) || (i_run_status == ST_RUN) ||
                  (i_run_status == ST_WAIT);
    assign o_stall = !(r_state == S_IDLE && i_out_free);
    assign take = i_valid && !o_stall;

    always_comb begin
        n_state = r_state; n_restart = r_restart;
        n_icode = r_icode; n_ibyte = r_ibyte; n_iv = r_iv; n_ie = r_ie;
        o_cmd = '0;
        o_cmd.instr_code = r_icode;
        o_cmd.in_byte = r_ibyte;
        o_cmd.in_valid = r_iv;
        o_cmd.in_eof = r_ie;
        o_done = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.cmd = DC_CLEAR;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                    o_done = r_restart;
                    n_restart = 1'b0;
                end
            end
            S_IDLE: begin
                if (take) begin
                    n_icode = i_instr_code; n_ibyte = i_in_byte;
                    n_iv = i_in_valid; n_ie = i_in_eof;
                    o_cmd.instr_code = i_instr_code;
                    priority case (i_command)
                        CMD_LOAD: begin o_cmd.cmd = DC_LOAD; o_done = 1'b1; end
                        CMD_STEP: begin
                            if (live) begin o_cmd.cmd = DC_FETCH; n_state = S_EXEC; end
                            else o_done = 1'b1;
                        end
                        CMD_RESTART: n_state = S_RST;
                        default: o_done = 1'b1;
                    endcase
                end
            end
            S_EXEC: begin
                o_cmd.cmd = DC_EXEC;
                o_done = i_stat.result;
                n_state = i_stat.skip_more ? S_SRD : S_IDLE;
            end
            S_SRD: begin
                o_cmd.cmd = DC_SKIP_RD;
                o_done = i_stat.result;
                n_state = i_stat.skip_more ? S_SEV : S_IDLE;
            end
            S_SEV: begin
                o_cmd.cmd = DC_SKIP_EV;
                o_done = i_stat.result;
                n_state = i_stat.skip_more ? S_SRD : S_IDLE;
            end
            S_RST: begin
                o_cmd.cmd = DC_RESTART;
                n_restart = 1'b1;
                n_state = S_CLR;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_restart <= 1'b0;
        end else begin
            r_state <= n_state;
            r_restart <= n_restart;
        end
        r_icode <= n_icode; r_ibyte <= n_ibyte; r_iv <= n_iv; r_ie <= n_ie;
    end
endmodule
`default_nettype wire

// ===== rtl/brainfuck_interpreter_core.sv =====
// Tape-language interpreter core: one command word in, one status word out.
// Input word: command (load, step, restart) with instruction and read-byte fields.
// Output word: status, out_valid and out_byte, held in an output register that is
// released by i_stall going low; a new word is taken only while that register is free.
// Load, unused commands and steps after halt or error answer in 1 cycle.
// A step of + - > < ] . and , runs a fetch of program store and tape, then an
// execute. A '[' on a zero cell then walks the program store, a read and an evaluate
// per scanned instruction, with one more read when no matching ']' is found.
// Restart and reset clear the tape one cell per cycle, all TAPE_DEPTH cells; no
// word is taken during either sweep, and a restart answers when its sweep ends.
// The program store is kept across restart.
// A stalled output holds its word, and the block accepts nothing until it is taken.
// Depends on bfi_pkg, bfi_control, bfi_datapath.
`default_nettype none
module brainfuck_interpreter_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [2:0] i_instr_code,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_eof,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_status,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte
);
    import bfi_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [2:0] run_state;
    logic     done, out_free;
    logic     r_valid;
    logic [2:0] r_status;
    logic     r_ov;
    logic [7:0] r_ob;

    assign out_free = !r_valid || !i_stall;

    bfi_control u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_instr_code(i_instr_code), .i_in_byte(i_in_byte),
        .i_in_valid(i_in_valid), .i_in_eof(i_in_eof), .i_run_status(run_state),
        .o_cmd(cmd), .i_stat(stat), .o_done(done), .i_out_free(out_free)
    );

    bfi_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat), .o_run(run_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (done) r_valid <= 1'b1;
        else if (!i_stall) r_valid <= 1'b0;
        if (done) begin
            r_status <= stat.status;
            r_ov <= stat.out_valid;
            r_ob <= stat.out_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_out_valid = r_ov;
    assign o_out_byte = r_ob;

    // a result only lands while the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> out_free) else $error("result over pending word");
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_valid) |-> (o_out_byte == 8'd0)) else $error("stray byte");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 3'd7)) else $error("bad status");
endmodule
`default_nettype wire

// ===== verif/bfi_checker.sv =====
// checker for the tape-language interpreter core: watches both word channels,
// keeps its own copy of program, tape and loop stack, compares every result
// depends on bfi_pkg
`default_nettype none
module bfi_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [2:0] i_instr_code,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_eof,
    input  wire logic       i_out_vld,
    input  wire logic       i_out_stall,
    input  wire logic [2:0] i_status,
    input  wire logic       i_out_valid,
    input  wire logic [7:0] i_out_byte,
    output int              o_errors,
    output int              o_pending
);
    import bfi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] status;
        logic       emit;
        logic [7:0] data;
    } t_result;

    logic [2:0]  prog [PROG_DEPTH];
    logic [7:0]  tape [TAPE_DEPTH];
    int          loop_pc [LOOP_DEPTH];
    int          prog_len, pc, cp, depth;
    logic [2:0]  state;
    t_result     expected_q[$];

    assign o_pending = expected_q.size();

    function automatic int find_close(int pos);
        int nest;
        nest = 0;
        for (int p = pos + 1; p < prog_len; p++) begin
            if (prog[p] == OP_OPEN) nest++;
            else if (prog[p] == OP_CLOSE) begin
                if (nest == 0) return p + 1;
                nest--;
            end
        end
        return prog_len;
    endfunction

    task automatic clear_run();
        foreach (tape[i]) tape[i] = 8'd0;
        cp = 0; pc = 0; depth = 0; state = ST_READY;
    endtask

    task automatic run_one(input logic [7:0] byte_in, input logic vin, input logic eof,
                           inout t_result r);
        if (pc >= prog_len) begin
            state = ST_HALT;
            return;
        end
        state = ST_RUN;
        case (prog[pc])
            OP_INC: begin tape[cp] = tape[cp] + 8'd1; pc++; end
            OP_DEC: begin tape[cp] = tape[cp] - 8'd1; pc++; end
            OP_RIGHT: begin
                if (cp + 1 >= TAPE_DEPTH) state = ST_TAPE_ERR;
                else begin cp++; pc++; end
            end
            OP_LEFT: begin
                if (cp == 0) state = ST_TAPE_ERR;
                else begin cp--; pc++; end
            end
            OP_OPEN: begin
                if (tape[cp] != 0) begin
                    if (depth >= LOOP_DEPTH) state = ST_LOOP_ERR;
                    else begin loop_pc[depth] = pc; depth++; pc++; end
                end else begin
                    pc = find_close(pc);
                    if (pc >= prog_len) state = ST_HALT;
                end
            end
            OP_CLOSE: begin
                if (depth == 0) state = ST_HALT;
                else begin depth--; pc = loop_pc[depth]; end
            end
            OP_READ: begin
                if (vin) begin tape[cp] = byte_in; pc++; end
                else if (eof) state = ST_HALT;
                else state = ST_WAIT;
            end
            default: begin r.emit = 1'b1; r.data = tape[cp]; pc++; end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result r, got;
        if (!i_rst_n) begin
            prog_len = 0;
            clear_run();
            expected_q.delete();
            o_errors <= 0;
        end else begin
            if (i_out_vld && !i_out_stall) begin
                got = '{i_status, i_out_valid, i_out_byte};
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with none expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    r = expected_q.pop_front();
                    if (r !== got) begin
                        $display("%0t: mismatch expected st=%0d ov=%0b ob=%h got st=%0d ov=%0b ob=%h",
                                 $time, r.status, r.emit, r.data, got.status, got.emit, got.data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                r = '0;
                case (i_command)
                    CMD_LOAD: begin
                        if (prog_len < PROG_DEPTH) begin
                            prog[prog_len] = i_instr_code;
                            prog_len++;
                            r.status = state;
                        end else r.status = ST_FULL;
                    end
                    CMD_STEP: begin
                        if (state == ST_READY || state == ST_RUN || state == ST_WAIT)
                            run_one(i_in_byte, i_in_valid, i_in_eof, r);
                        r.status = state;
                    end
                    CMD_RESTART: begin
                        clear_run();
                        r.status = state;
                    end
                    default: r.status = state;
                endcase
                expected_q.push_back(r);
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_brainfuck_interpreter_core.sv =====
// stimulus and verdict for the tape-language interpreter core
// drives program loads, steps and restarts with random gaps; bfi_checker judges
// depends on bfi_pkg, bfi_checker, brainfuck_interpreter_core
`default_nettype none
module tb_brainfuck_interpreter_core;
    import bfi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_command = CMD_RESTART;
    logic [2:0] i_instr_code = OP_INC;
    logic [7:0] i_in_byte = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       i_in_eof = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b1;
    logic [2:0] o_status;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    int         errors, pending;
    int         quiet_cycles;
    bit         calm, hold_off, hold_go;

    always #10 i_clk = ~i_clk;

    brainfuck_interpreter_core dut (.*);

    bfi_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_command, .i_instr_code,
        .i_in_byte, .i_in_valid, .i_in_eof, .i_out_vld(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_out_valid(o_out_valid), .i_out_byte(o_out_byte),
        .o_errors(errors), .o_pending(pending)
    );

    // sends one word and holds it until taken, with an optional idle gap first
    task automatic send_word(input logic [1:0] cmd, input logic [2:0] code,
                             input logic [7:0] b, input logic v, input logic eof);
        if (!calm) begin
            while ($urandom_range(99) < 25) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_instr_code <= code;
        i_in_byte <= b;
        i_in_valid <= v;
        i_in_eof <= eof;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic load_op(input logic [2:0] code);
        send_word(CMD_LOAD, code, 8'd0, 1'b0, 1'b0);
    endtask

    task automatic step_op(input logic [7:0] b, input logic v, input logic eof);
        send_word(CMD_STEP, OP_INC, b, v, eof);
    endtask

    // random step with input offered most of the time
    task automatic step_rand();
        step_op(8'($urandom_range(255)), $urandom_range(9) < 7, $urandom_range(3) == 0);
    endtask

    // receiver: random stalls, a stall-free stretch and one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (calm) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 25);
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || hold_off)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        calm = 0;
        hold_go = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every opcode but left, end of program, read cases
        load_op(OP_INC);
        step_rand();
        send_word(CMD_UNUSED, OP_WRITE, 8'hff, 1'b1, 1'b1);
        step_rand();
        send_word(CMD_RESTART, OP_INC, 8'd0, 1'b0, 1'b0);
        load_op(OP_READ); load_op(OP_WRITE); load_op(OP_DEC); load_op(OP_WRITE);
        load_op(OP_OPEN); load_op(OP_DEC); load_op(OP_CLOSE); load_op(OP_OPEN);
        load_op(OP_CLOSE); load_op(OP_RIGHT);
        send_word(CMD_RESTART, OP_INC, 8'd0, 1'b0, 1'b0);
        step_op(8'hff, 1'b0, 1'b0);
        step_op(8'hff, 1'b0, 1'b0);
        step_op(8'h00, 1'b0, 1'b1);
        send_word(CMD_RESTART, OP_INC, 8'd0, 1'b0, 1'b0);
        step_op(8'h03, 1'b0, 1'b0);
        step_op(8'h03, 1'b1, 1'b0);
        repeat (14) step_rand();

        // random programs, mostly random opcodes, some balanced loops, some stray brackets
        for (int prog_no = 0; prog_no < 8; prog_no++) begin
            int n;
            if (prog_no == 1) hold_go = 1;
            if (prog_no == 4) calm = 1;
            if (prog_no == 6) calm = 0;
            n = $urandom_range(8, 20);
            for (int k = 0; k < n; k++) begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 12) begin
                    load_op(OP_OPEN); load_op(OP_DEC); load_op(OP_WRITE); load_op(OP_CLOSE);
                end else if (pick < 16) load_op($urandom_range(1) ? OP_OPEN : OP_CLOSE);
                else load_op(3'($urandom_range(7)));
            end
            for (int k = 0; k < 30; k++) begin
                if ($urandom_range(29) == 0)
                    send_word(CMD_RESTART, OP_INC, 8'd0, 1'b0, 1'b0);
                else step_rand();
            end
        end

        // deep nesting: loads more opens than the loop stack holds, then steps
        send_word(CMD_RESTART, OP_INC, 8'd0, 1'b0, 1'b0);
        load_op(OP_INC);
        for (int k = 0; k < LOOP_DEPTH + 1; k++) load_op(OP_OPEN);
        for (int k = 0; k < LOOP_DEPTH + 3; k++) step_rand();
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/bfi_pkg.sv
rtl/bfi_datapath.sv
rtl/bfi_control.sv
rtl/brainfuck_interpreter_core.sv
verif/bfi_checker.sv
verif/tb_brainfuck_interpreter_core.sv
